// File: rtl/icdt_pkg.sv
package icdt_pkg;

	localparam int MaxLeaves  = 1024;
	localparam int LeafBits   = 11;
	localparam int NodeBits   = 12;
	localparam int CoordBits  = 32;
	localparam int TabBits    = 11;
	localparam int DepthBits  = 5;
	localparam int StackDepth = 32;

	localparam logic [1:0] ReqLoad   = 2'd0;
	localparam logic [1:0] ReqClear  = 2'd1;
	localparam logic [1:0] ReqUpdate = 2'd2;

	typedef struct packed {
		logic [15:0] cnt;
		logic [31:0] l1;
		logic [31:0] l2;
		logic [31:0] l3;
	} node_t;

	typedef struct packed {
		logic [NodeBits-1:0] k;
		logic [LeafBits-1:0] l;
		logic [LeafBits-1:0] r;
		logic                post;
	} frame_t;

endpackage

// File: rtl/interval_cover_depth_tree_unit.sv
// interval coverage tree, sweep-line segment tree over a coordinate table
// s_axis_* carries one request beat: load a coordinate, clear the tree or add
// a +1/-1 cover delta to a range of leaves. every request gives exactly one
// m_axis_* beat holding the root length covered three or more times.
// leaves_in_use is written through cfg_wen/cfg_wdata; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// the node records live in one synchronous memory with one read and one
// write port and a registered read; an update walks the tree with an
// explicit stack, visiting each touched node, reading its children and
// writing it back. each node written back passes through pop, read self,
// read both children and write, and the final pop and root read precede the
// beat; a load, an unused request or an empty range goes to the root read.
// a clear sweeps all 4096 node entries, one per cycle; after reset the same
// sweep runs before the first request is accepted. the result is held in an
// output register; a new request is taken only once that beat has left, so
// a stalled receiver simply stalls the input side. the coordinate table is
// never cleared: the user must load every slot before use; nothing checks it.
module interval_cover_depth_tree_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [10:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [1:0] req_type, [12:2] coord_index, [44:13] coord_value,
	// [55:45] left_leaf, [66:56] right_leaf, [68:67] delta, zero pad
	input  logic [71:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [31:0] triple_cover_length
	output logic [31:0] m_axis_tdata
);
	localparam int NB = icdt_pkg::NodeBits;
	localparam int LB = icdt_pkg::LeafBits;

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_POP, ST_RD_SELF, ST_RD_A, ST_RD_B, ST_CALC,
		ST_ROOT, ST_ROOT_W, ST_OUT
	} state_t;

	state_t state_q;
	logic [10:0] leaves_q;
	logic [NB-1:0] clr_q;

	// node memory
	icdt_pkg::node_t nmem [0:(1<<NB)-1];
	logic            nwe;
	logic [NB-1:0]   nwa, nra;
	icdt_pkg::node_t nwd, nrd_q;
	always_ff @(posedge clk) begin
		if (nwe) nmem[nwa] <= nwd;
		nrd_q <= nmem[nra];
	end

	// coordinate table, two read ports
	logic [31:0] ctab [0:(1<<icdt_pkg::TabBits)-1];
	logic        cwe;
	logic [icdt_pkg::TabBits-1:0] cwa, cra0, cra1;
	logic [31:0] cwd, crd0_q, crd1_q;
	always_ff @(posedge clk) begin
		if (cwe) ctab[cwa] <= cwd;
		crd0_q <= ctab[cra0];
		crd1_q <= ctab[cra1];
	end

	icdt_pkg::frame_t stk_q [0:icdt_pkg::StackDepth-1];
	logic [icdt_pkg::DepthBits:0] sp_q;
	icdt_pkg::frame_t cur_q;
	logic [LB-1:0] lo_q, hi_q;
	logic [1:0] d_q;
	icdt_pkg::node_t self_q, ca_q;
	logic [31:0] res_q;

	wire [1:0]  rt  = s_axis_tdata[1:0];
	wire [10:0] ci  = s_axis_tdata[12:2];
	wire [31:0] cv  = s_axis_tdata[44:13];
	wire [10:0] ll  = s_axis_tdata[55:45];
	wire [10:0] rl  = s_axis_tdata[66:56];
	wire [1:0]  dl  = s_axis_tdata[68:67];

	wire [10:0] n_eff = (leaves_q == 11'd0) ? 11'd1 :
		(leaves_q > 11'(icdt_pkg::MaxLeaves)) ? 11'(icdt_pkg::MaxLeaves) : leaves_q;
	wire [10:0] lo_eff = (ll == 11'd0) ? 11'd1 : ll;
	wire [10:0] hi_eff = (rl > n_eff) ? n_eff : rl;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = res_q;

	wire covered = (lo_q <= cur_q.l) && (hi_q >= cur_q.r);
	wire [LB-1:0] mid = LB'(({1'b0, cur_q.l} + {1'b0, cur_q.r}) >> 1);
	wire leaf = (cur_q.l == cur_q.r);
	icdt_pkg::frame_t top;
	assign top = stk_q[sp_q[icdt_pkg::DepthBits-1:0] - 1'b1];

	// new count for a covered node, saturating
	logic [17:0] csum;
	logic [15:0] cnew;
	always_comb begin
		csum = {2'b00, self_q.cnt} + {{16{d_q[1]}}, d_q};
		if (csum[17]) cnew = 16'd0;
		else if (csum[16]) cnew = 16'hffff;
		else cnew = csum[15:0];
	end

	// recompute from count, span and children (child b in nrd_q)
	logic [31:0] span, c1, c2, c3;
	logic [15:0] cuse;
	icdt_pkg::node_t rec;
	always_comb begin
		span = crd1_q - crd0_q;
		c1 = leaf ? 32'd0 : ca_q.l1 + nrd_q.l1;
		c2 = leaf ? 32'd0 : ca_q.l2 + nrd_q.l2;
		c3 = leaf ? 32'd0 : ca_q.l3 + nrd_q.l3;
		cuse = cur_q.post ? self_q.cnt : cnew;
		rec.cnt = cuse;
		if (cuse >= 16'd3) begin
			rec.l3 = span; rec.l2 = span; rec.l1 = span;
		end else if (cuse == 16'd2) begin
			rec.l3 = c1; rec.l2 = span; rec.l1 = span;
		end else if (cuse == 16'd1) begin
			rec.l3 = c2; rec.l2 = c1; rec.l1 = span;
		end else begin
			rec.l3 = c3; rec.l2 = c2; rec.l1 = c1;
		end
	end

	always_comb begin
		nwe = 1'b0; nwa = cur_q.k; nwd = rec; nra = cur_q.k;
		cwe = 1'b0; cwa = ci[icdt_pkg::TabBits-1:0]; cwd = cv;
		cra0 = cur_q.l; cra1 = cur_q.r + 1'b1;
		case (state_q)
			ST_CLR: begin
				nwe = 1'b1; nwa = clr_q; nwd = '0;
			end
			ST_IDLE: begin
				cwe = s_axis_tvalid && rt == icdt_pkg::ReqLoad && ci != 11'd0 &&
					ci <= 11'(icdt_pkg::MaxLeaves + 1);
				nra = NB'(1);
			end
			ST_RD_A: nra = {cur_q.k[NB-2:0], 1'b0};
			ST_RD_B: nra = {cur_q.k[NB-2:0], 1'b1};
			ST_CALC: nwe = 1'b1;
			ST_ROOT: nra = NB'(1);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			leaves_q <= 11'd1;
			clr_q <= '0;
			sp_q <= '0;
		end else begin
			if (cfg_wen) leaves_q <= cfg_wdata;
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) state_q <= (sp_q != '0) ? ST_ROOT : ST_IDLE;
				end
				ST_IDLE: if (s_axis_tvalid) begin
					lo_q <= lo_eff; hi_q <= hi_eff; d_q <= dl;
					if (rt == icdt_pkg::ReqClear) begin
						// nonzero sp_q sends the sweep on to the root read
						state_q <= ST_CLR; sp_q <= {{icdt_pkg::DepthBits{1'b0}}, 1'b1};
					end else if (rt == icdt_pkg::ReqUpdate && lo_eff <= hi_eff) begin
						sp_q <= '0;
						cur_q <= '{k: NB'(1), l: LB'(1), r: n_eff, post: 1'b0};
						state_q <= ST_RD_SELF;
					end else begin
						sp_q <= '0; state_q <= ST_ROOT;
					end
				end
				ST_POP: begin
					if (sp_q == '0) state_q <= ST_ROOT;
					else begin
						cur_q <= top; sp_q <= sp_q - 1'b1; state_q <= ST_RD_SELF;
					end
				end
				ST_RD_SELF: state_q <= ST_RD_A;
				ST_RD_A: begin
					self_q <= nrd_q;
					if (!cur_q.post && !covered) begin
						// descend: push post frame and right child if needed; enter left or pop
						stk_q[sp_q[icdt_pkg::DepthBits-1:0]] <= '{k: cur_q.k, l: cur_q.l,
							r: cur_q.r, post: 1'b1};
						if (hi_q > mid) begin
							stk_q[sp_q[icdt_pkg::DepthBits-1:0] + 1'b1] <=
								'{k: {cur_q.k[NB-2:0], 1'b1}, l: mid + 1'b1,
								r: cur_q.r, post: 1'b0};
							sp_q <= sp_q + 2'd2;
						end else sp_q <= sp_q + 1'b1;
						if (lo_q <= mid) begin
							cur_q <= '{k: {cur_q.k[NB-2:0], 1'b0}, l: cur_q.l, r: mid,
								post: 1'b0};
							state_q <= ST_RD_SELF;
						end else state_q <= ST_POP;
					end else state_q <= ST_RD_B;
				end
				ST_RD_B: begin
					ca_q <= nrd_q; state_q <= ST_CALC;
				end
				ST_CALC: state_q <= ST_POP;
				ST_ROOT: state_q <= ST_ROOT_W;
				ST_ROOT_W: begin
					res_q <= nrd_q.l3; state_q <= ST_OUT;
				end
				ST_OUT: if (m_axis_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
